// File: rtl/ogd_pkg.sv
// Shared types and constants for the occupancy grid dilation block.
// No dependencies; every other file in rtl imports this package.
package ogd_pkg;

  localparam int VALUE_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_ADDR_W   = 2;
  localparam int MAP_WIDTH_W  = 11;
  localparam int MAP_HEIGHT_W = 16;

  localparam logic [MAP_WIDTH_W-1:0]  MAP_WIDTH_RST  = 11'd1024;
  localparam logic [MAP_HEIGHT_W-1:0] MAP_HEIGHT_RST = 16'd1024;
  localparam logic [VALUE_W-1:0]      THRESHOLD_RST  = 16'd256;
  localparam logic [VALUE_W-1:0]      FILL_VALUE_RST = 16'd256;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_THRESHOLD  = 2'd2,
    CFG_FILL_VALUE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    logic               is_padding;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] dilated_value;
    logic               last_cell;
  } out_beat_t;

  // One history entry: occupancy of its own cell and of the two cells before
  // it, plus the value of the cell before it.
  typedef struct packed {
    logic [VALUE_W-1:0] prev_value;
    logic               occ;
    logic               prev_occ;
    logic               prev2_occ;
  } line_entry_t;

endpackage

// File: rtl/ogd_line_store.sv
// History memory for the dilation block: one write port, two read ports,
// registered read data. Depends on ogd_pkg.
module ogd_line_store #(
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  ogd_pkg::line_entry_t wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr_a,
  input  logic [ADDR_W-1:0]   rd_addr_b,
  output ogd_pkg::line_entry_t rd_data_a,
  output ogd_pkg::line_entry_t rd_data_b
);
  import ogd_pkg::*;

  line_entry_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: rtl/occupancy_grid_dilation_top.sv
// Occupancy grid dilation, six-neighbour 3x3, raster stream in and out.
// Depends on ogd_pkg and ogd_line_store.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_we               cfg_addr, cfg_wdata
//   in       in   in_valid/in_ready    in_beat (cell_value, is_padding)
//   out      out  out_valid/out_ready  out_beat (dilated_value, last_cell)
//
// One beat per cycle unless output stalls; results pass stage, then out_beat regs.
// The history memory is read at two ages and written once per beat.
// Synchronous reset clears pointers, counters and previous-cell occupancy flags.
// No clearing pass: a history fill count masks entries not yet written.
// in_ready drops only while a result waits and the output is stalled.
module occupancy_grid_dilation_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ogd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ogd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ogd_pkg::in_beat_t                 in_beat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ogd_pkg::out_beat_t                out_beat
);
  import ogd_pkg::*;

  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int FW       = $clog2(MAX_WIDTH + 2);
  localparam int AW       = $clog2(2 * MAX_WIDTH + 3);
  localparam int HIST_MAX = 2 * MAX_WIDTH + 2;

  typedef struct packed {
    logic produce;
    logic occ0;
    logic occ1;
    logic has_left;
    logic has_up;
    logic has_right;
    logic has_down;
    logic last;
    logic valid_a;
    logic valid_b;
  } stage_t;

  logic [MAP_WIDTH_W-1:0]  map_width;
  logic [MAP_HEIGHT_W-1:0] map_height;
  logic [VALUE_W-1:0]      occupied_threshold;
  logic [VALUE_W-1:0]      fill_value;

  logic [WW-1:0]           width_eff;
  logic [MAP_HEIGHT_W-1:0] height_eff;

  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      hist_count;
  logic               prev_occ;
  logic               prev2_occ;
  logic [VALUE_W-1:0] prev_value;

  logic [FW-1:0]           fill_count;
  logic [CW-1:0]           out_column;
  logic [MAP_HEIGHT_W-1:0] out_row;

  logic               in_fire;
  logic               cur_occ;
  logic [VALUE_W-1:0] cur_value;
  logic               priming;
  logic [AW-1:0]      age_a;
  logic [AW-1:0]      age_b;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  line_entry_t        wr_entry;
  line_entry_t        rd_data_a;
  line_entry_t        rd_data_b;
  stage_t             stage_next;
  stage_t             stage;
  logic               stage_valid;

  logic               out_free;
  logic               hit;
  logic [VALUE_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width          <= MAP_WIDTH_RST;
      map_height         <= MAP_HEIGHT_RST;
      occupied_threshold <= THRESHOLD_RST;
      fill_value         <= FILL_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_MAP_WIDTH:  map_width          <= cfg_wdata[MAP_WIDTH_W-1:0];
        CFG_MAP_HEIGHT: map_height         <= cfg_wdata[MAP_HEIGHT_W-1:0];
        CFG_THRESHOLD:  occupied_threshold <= cfg_wdata[VALUE_W-1:0];
        CFG_FILL_VALUE: fill_value         <= cfg_wdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_width == '0) begin
      width_eff = WW'(1);
    end else if (32'(map_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(map_width);
    end
    height_eff = (map_height == '0) ? MAP_HEIGHT_W'(1) : map_height;
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = !stage_valid || !stage.produce || out_free;
  assign in_fire  = in_valid && in_ready;

  assign cur_occ   = !in_beat.is_padding && (in_beat.cell_value >= occupied_threshold);
  assign cur_value = in_beat.is_padding ? '0 : in_beat.cell_value;

  // Entry at age w carries ages w, w+1, w+2; entry at age 2w+1 carries 2w+1, 2w+2.
  assign age_a     = AW'(width_eff);
  assign age_b     = AW'({width_eff, 1'b1});
  assign rd_addr_a = wr_ptr - age_a;
  assign rd_addr_b = wr_ptr - age_b;

  always_comb begin
    wr_entry.prev_value = prev_value;
    wr_entry.occ        = cur_occ;
    wr_entry.prev_occ   = prev_occ;
    wr_entry.prev2_occ  = prev2_occ;
  end

  ogd_line_store #(
    .ADDR_W(AW)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (wr_ptr),
    .wr_data   (wr_entry),
    .rd_en     (in_fire),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign priming = 32'(fill_count) <= 32'(width_eff);

  always_comb begin
    stage_next.produce   = !priming;
    stage_next.occ0      = cur_occ;
    stage_next.occ1      = prev_occ;
    stage_next.has_left  = out_column != '0;
    stage_next.has_up    = out_row != '0;
    stage_next.has_right = (32'(out_column) + 32'd1) < 32'(width_eff);
    stage_next.has_down  = (32'(out_row) + 32'd1) < 32'(height_eff);
    stage_next.last      = !stage_next.has_right && !stage_next.has_down;
    stage_next.valid_a   = age_a <= hist_count;
    stage_next.valid_b   = age_b <= hist_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      hist_count <= '0;
      prev_occ   <= 1'b0;
      prev2_occ  <= 1'b0;
      fill_count <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (in_fire) begin
      wr_ptr    <= wr_ptr + AW'(1);
      prev2_occ <= prev_occ;
      prev_occ  <= cur_occ;
      if (32'(hist_count) < 32'(HIST_MAX)) begin
        hist_count <= hist_count + AW'(1);
      end
      if (priming) begin
        fill_count <= fill_count + FW'(1);
      end else if (stage_next.last) begin
        fill_count <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else if (!stage_next.has_right) begin
        out_column <= '0;
        out_row    <= out_row + MAP_HEIGHT_W'(1);
      end else begin
        out_column <= out_column + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev_value <= cur_value;
      stage      <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_fire;
    end
  end

  always_comb begin
    hit = (stage.has_left  && stage.valid_a && rd_data_a.prev2_occ)
       || (stage.has_up    && stage.valid_b && rd_data_b.occ)
       || (stage.has_left  && stage.has_up && stage.valid_b && rd_data_b.prev_occ)
       || (stage.has_right && stage.valid_a && rd_data_a.occ)
       || (stage.has_down  && stage.occ1)
       || (stage.has_right && stage.has_down && stage.occ0);
    result = hit ? fill_value : rd_data_a.prev_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid && stage.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid && stage.produce) begin
      out_beat.dilated_value <= result;
      out_beat.last_cell     <= stage.last;
    end
  end

endmodule
